[hdl/pcd_pkg.sv]
`default_nettype none
package pcd_pkg;

	// Column stream terminator
	localparam logic [7:0] END_MARK = 8'hFF;

	// Field widths
	localparam int ROW_W    = 12;
	localparam int PIXEL_W  = 8;
	localparam int ORIGIN_W = 16;
	localparam int CURROW_W = 18;

	// Register file
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_ORIGIN = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [ORIGIN_W-1:0] ORIGIN_RESET = 16'd0;
	localparam logic [ROW_W-1:0]    HEIGHT_RESET = 12'd128;

	// Parser phases
	typedef enum logic [2:0] {
		PH_TOP      = 3'd0,
		PH_LEN      = 3'd1,
		PH_PAD_HEAD = 3'd2,
		PH_PIXELS   = 3'd3,
		PH_PAD_TAIL = 3'd4
	} phase_t;

	// One result item
	typedef struct packed {
		logic               write_valid;
		logic [ROW_W-1:0]   row;
		logic [PIXEL_W-1:0] pixel;
		logic               column_end;
	} result_t;

endpackage
`default_nettype wire

[hdl/pcd_obuf.sv]
`default_nettype none
module pcd_obuf (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  pcd_pkg::result_t push_data,
	output logic             full,
	output logic             out_valid,
	input  wire              out_ready,
	output pcd_pkg::result_t out_data
);
	import pcd_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_data_q;
	result_t skid_data_q;
	logic    pop;

	assign pop       = out_valid_q && out_ready;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Track occupancy of the output and skid entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (push) begin
					out_valid_q <= 1'b1;
				end else begin
					out_valid_q  <= skid_valid_q;
					skid_valid_q <= 1'b0;
				end
			end else if (push) begin
				if (out_valid_q) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	// Move payloads; a push only happens while the skid entry is empty
	always_ff @(posedge clk) begin
		if (pop) begin
			if (push) begin
				out_data_q <= push_data;
			end else begin
				out_data_q <= skid_data_q;
			end
		end else if (push) begin
			if (out_valid_q) begin
				skid_data_q <= push_data;
			end else begin
				out_data_q <= push_data;
			end
		end
	end

endmodule
`default_nettype wire

[hdl/post_column_clip_decoder_unit.sv]
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_ready    column_byte
// result    out        out_valid / out_ready  write_valid, row, pixel, column_end
// config    in         APB psel / penable     paddr, pwdata, prdata
//
// One column byte is taken per cycle while in_ready is high; its result, if
// any, is registered. The parser state is one short add and compare deep.
// A two-entry result buffer (output register plus skid) keeps input flowing
// while a result waits; in_ready drops only when both entries are full.
// Reset puts the parser at the top-offset byte, origin_row 0, height 128.
`default_nettype none
module post_column_clip_decoder_unit (
	input  wire                         clk,
	input  wire                         arst_n,
	// Column byte stream
	input  wire                         in_valid,
	output logic                        in_ready,
	input  wire  [7:0]                  column_byte,
	// Results
	output logic                        out_valid,
	input  wire                         out_ready,
	output logic                        write_valid,
	output logic [pcd_pkg::ROW_W-1:0]   row,
	output logic [pcd_pkg::PIXEL_W-1:0] pixel,
	output logic                        column_end,
	// Configuration
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire  [pcd_pkg::PADDR_W-1:0] paddr,
	input  wire  [pcd_pkg::PDATA_W-1:0] pwdata,
	output logic [pcd_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import pcd_pkg::*;

	logic [ORIGIN_W-1:0] origin_row_q;
	logic [ROW_W-1:0]    column_height_q;

	phase_t              phase_q, phase_d;
	logic [CURROW_W-1:0] cur_row_q, cur_row_d;
	logic [7:0]          bytes_left_q, bytes_left_d;

	logic    accept;
	logic    res_push;
	result_t res;
	result_t out_res;
	logic    skid_full;
	logic    row_inside;
	logic    reg_idx;
	logic    cfg_write;

	// Configuration port
	assign pready    = 1'b1;
	assign reg_idx   = paddr[2];
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_row_q    <= ORIGIN_RESET;
			column_height_q <= HEIGHT_RESET;
		end else if (cfg_write) begin
			if (reg_idx == REG_ORIGIN) begin
				origin_row_q <= pwdata[ORIGIN_W-1:0];
			end else begin
				column_height_q <= pwdata[ROW_W-1:0];
			end
		end
	end

	always_comb begin
		if (reg_idx == REG_ORIGIN) begin
			prdata = {{(PDATA_W-ORIGIN_W){origin_row_q[ORIGIN_W-1]}}, origin_row_q};
		end else begin
			prdata = {{(PDATA_W-ROW_W){1'b0}}, column_height_q};
		end
	end

	// Input handshake
	assign in_ready = !skid_full;
	assign accept   = in_valid && in_ready;

	// Row window check on the current pixel row
	assign row_inside = !cur_row_q[CURROW_W-1] &&
		(cur_row_q[CURROW_W-2:0] < {{(CURROW_W-1-ROW_W){1'b0}}, column_height_q});

	// Parse one byte
	always_comb begin
		phase_d      = phase_q;
		cur_row_d    = cur_row_q;
		bytes_left_d = bytes_left_q;
		res_push     = 1'b0;
		res          = '0;
		case (phase_q)
			PH_LEN: begin
				bytes_left_d = column_byte;
				phase_d      = PH_PAD_HEAD;
			end
			PH_PAD_HEAD: begin
				phase_d = (bytes_left_q != 8'd0) ? PH_PIXELS : PH_PAD_TAIL;
			end
			PH_PIXELS: begin
				cur_row_d    = cur_row_q + {{(CURROW_W-1){1'b0}}, 1'b1};
				bytes_left_d = bytes_left_q - 8'd1;
				if (bytes_left_q == 8'd1) begin
					phase_d = PH_PAD_TAIL;
				end
				if (row_inside) begin
					res_push        = 1'b1;
					res.write_valid = 1'b1;
					res.row         = cur_row_q[ROW_W-1:0];
					res.pixel       = column_byte;
				end
			end
			PH_PAD_TAIL: begin
				phase_d = PH_TOP;
			end
			default: begin
				if (column_byte == END_MARK) begin
					phase_d        = PH_TOP;
					bytes_left_d   = 8'd0;
					res_push       = 1'b1;
					res.column_end = 1'b1;
				end else begin
					cur_row_d = {{(CURROW_W-ORIGIN_W){origin_row_q[ORIGIN_W-1]}}, origin_row_q}
						+ {{(CURROW_W-8){1'b0}}, column_byte};
					phase_d   = PH_LEN;
				end
			end
		endcase
	end

	// Advance parser state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_TOP;
			cur_row_q    <= '0;
			bytes_left_q <= 8'd0;
		end else if (accept) begin
			phase_q      <= phase_d;
			cur_row_q    <= cur_row_d;
			bytes_left_q <= bytes_left_d;
		end
	end

	// Result buffer
	pcd_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && res_push),
		.push_data (res),
		.full      (skid_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_res)
	);

	assign write_valid = out_res.write_valid;
	assign row         = out_res.row;
	assign pixel       = out_res.pixel;
	assign column_end  = out_res.column_end;

`ifndef SYNTHESIS
	// A result is either a pixel write or a column end, never both or neither
	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (write_valid ^ column_end))
		else $error("result is neither a single write nor a single column end");

	// Pixel phase always has pixels left to consume
	a_pixels_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PIXELS) |-> (bytes_left_q != 8'd0))
		else $error("pixel phase with no pixels left");

	// A pending write lies inside the column
	a_row_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && write_valid) |-> (row < column_height_q))
		else $error("write row outside the column");

	// The last pixel of a post leads to the trailing pad
	a_post_close: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_q == PH_PIXELS && bytes_left_q == 8'd1) |=> (phase_q == PH_PAD_TAIL))
		else $error("post did not close after its last pixel");
`endif

endmodule
`default_nettype wire
